[hw/rtl/hat_pkg.sv]
package hat_pkg;

   localparam logic [1:0] KIND_ACCUM = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_MERGED   = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_DONE     = 2'd3;

   localparam logic [63:0] MIX_MUL1  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL2  = 64'hc4ceb9fe1a85ec53;
   localparam int unsigned MIX_SHIFT = 33;

   typedef struct packed {
      logic [1:0]         kind;
      logic [63:0]        key;
      logic [63:0]        value_low;
      logic signed [63:0] value_high;
      logic [11:0]        slot_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               occupied;
      logic [63:0]        found_key;
      logic [63:0]        sum_low;
      logic signed [63:0] sum_high;
      logic [11:0]        entries;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [63:0] acc_low;
      logic [63:0] acc_high;
   } slot_type;

endpackage

[hw/rtl/hash_accumulate_table.sv]
// accumulate: key mix in ST_HASH, then ST_PROBE_RD, ST_PROBE_CHK once per probe step, then ST_DONE;
// the key mix runs two 64-bit multiplies through one shared 32x32 multiplier
// read: one registered read of the slot memory
// clear: one slot emptied per cycle through the single write port
// throughput: one word at a time; a new word is taken while the last result waits
// reset: entry count zeroed, then a clearing pass over every slot with req_stall high
module hash_accumulate_table #(
   parameter int LOG_SLOTS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hat_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hat_pkg::rsp_word_type rsp_word
);

   import hat_pkg::*;

   localparam int SLOTS = 1 << LOG_SLOTS;
   localparam logic [LOG_SLOTS-1:0] FILL_LIMIT = LOG_SLOTS'((64'd1 << LOG_SLOTS) * 3 / 4);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_CLEAR     = 7'b0000010,
      ST_HASH      = 7'b0000100,
      ST_PROBE_RD  = 7'b0001000,
      ST_PROBE_CHK = 7'b0010000,
      ST_READ_CHK  = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [LOG_SLOTS-1:0] count_ff, count_in;
   logic [LOG_SLOTS-1:0] clr_addr_ff, clr_addr_in;
   logic clr_reply_ff, clr_reply_in;
   logic [1:0] phase_ff, phase_in;
   logic round_ff, round_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [63:0] h_ff, h_in;
   logic [63:0] mac_ff, mac_in;
   logic [LOG_SLOTS-1:0] probe_addr_ff, probe_addr_in;
   req_word_type item_ff, item_in;
   rsp_word_type res_ff, res_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic wr_en;
   logic [LOG_SLOTS-1:0] wr_addr, rd_addr;
   slot_type wr_slot, rd_slot;

   logic req_accept;
   logic [31:0] mul_a, mul_c;
   logic [63:0] mul_const, prod, mac_next, mixed;
   logic [127:0] sum128;

   hat_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_slot),
      .rd_addr(rd_addr),
      .rd_data(rd_slot)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // one 32x32-bit partial product per cycle, low 64 bits of the full product kept
   assign mul_const = round_ff ? MIX_MUL2 : MIX_MUL1;
   assign mul_a     = (phase_ff == 2'd2) ? h_ff[63:32] : h_ff[31:0];
   assign mul_c     = (phase_ff == 2'd1) ? mul_const[63:32] : mul_const[31:0];
   assign prod      = mul_a * mul_c;
   assign mac_next  = (phase_ff == 2'd0) ? prod : mac_ff + {prod[31:0], 32'd0};
   assign mixed     = mac_next ^ (mac_next >> MIX_SHIFT);

   assign sum128 = {rd_slot.acc_high, rd_slot.acc_low}
                 + {item_ff.value_high, item_ff.value_low};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      clr_reply_in  = clr_reply_ff;
      phase_in      = phase_ff;
      round_in      = round_ff;
      h_in          = h_ff;
      mac_in        = mac_ff;
      probe_addr_in = probe_addr_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = probe_addr_ff;
      wr_slot       = '0;
      rd_addr       = probe_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = LOG_SLOTS'(req_word.slot_index);
            if (req_accept) begin
               item_in = req_word;
               res_in  = '0;
               unique case (req_word.kind)
                  KIND_ACCUM: begin
                     h_in     = req_word.key ^ (req_word.key >> MIX_SHIFT);
                     phase_in = 2'd0;
                     round_in = 1'b0;
                     state_in = ST_HASH;
                  end
                  KIND_READ: begin
                     state_in = ST_READ_CHK;
                  end
                  KIND_CLEAR: begin
                     count_in     = '0;
                     clr_addr_in  = '0;
                     clr_reply_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     res_in.status = STATUS_DONE;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               res_in        = '0;
               res_in.status = STATUS_DONE;
               state_in      = clr_reply_ff ? ST_DONE : ST_IDLE;
               clr_reply_in  = 1'b0;
            end
         end

         ST_HASH: begin
            mac_in   = mac_next;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd2) begin
               h_in     = mixed;
               phase_in = 2'd0;
               round_in = 1'b1;
               if (round_ff) begin
                  probe_addr_in = LOG_SLOTS'(mixed);
                  state_in      = ST_PROBE_RD;
               end
            end
         end

         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end

         ST_PROBE_CHK: begin
            // read the next slot ahead; used only when this one misses
            rd_addr = probe_addr_ff + 1'b1;
            if (!rd_slot.valid) begin
               res_in = '0;
               if (count_ff >= FILL_LIMIT) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  wr_en            = 1'b1;
                  wr_slot.valid    = 1'b1;
                  wr_slot.key      = item_ff.key;
                  wr_slot.acc_low  = item_ff.value_low;
                  wr_slot.acc_high = item_ff.value_high;
                  count_in         = count_ff + 1'b1;
                  res_in.status    = STATUS_INSERTED;
                  res_in.occupied  = 1'b1;
                  res_in.found_key = item_ff.key;
                  res_in.sum_low   = item_ff.value_low;
                  res_in.sum_high  = item_ff.value_high;
               end
               state_in = ST_DONE;
            end else if (rd_slot.key == item_ff.key) begin
               wr_en            = 1'b1;
               wr_slot.valid    = 1'b1;
               wr_slot.key      = item_ff.key;
               wr_slot.acc_low  = sum128[63:0];
               wr_slot.acc_high = sum128[127:64];
               res_in           = '0;
               res_in.status    = STATUS_MERGED;
               res_in.occupied  = 1'b1;
               res_in.found_key = item_ff.key;
               res_in.sum_low   = sum128[63:0];
               res_in.sum_high  = sum128[127:64];
               state_in         = ST_DONE;
            end else begin
               probe_addr_in = probe_addr_ff + 1'b1;
            end
         end

         ST_READ_CHK: begin
            res_in        = '0;
            res_in.status = STATUS_DONE;
            if (rd_slot.valid) begin
               res_in.occupied  = 1'b1;
               res_in.found_key = rd_slot.key;
               res_in.sum_low   = rd_slot.acc_low;
               res_in.sum_high  = rd_slot.acc_high;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in         = res_ff;
               rsp_word_in.entries = 12'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         phase_ff     <= 2'd0;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff          <= h_in;
      mac_ff        <= mac_in;
      probe_addr_ff <= probe_addr_in;
      item_ff       <= item_in;
      res_ff        <= res_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FILL_LIMIT)
      else $error("entry count above fill limit");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_PROBE_CHK || state_ff == ST_CLEAR))
      else $error("slot write outside probe or clear");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> count_ff == '0)
      else $error("entry count not zero during clear");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.kind == KIND_ACCUM |=> state_ff == ST_HASH)
      else $error("accumulate word did not start the key mix");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside done state");

endmodule

[hw/rtl/hat_ram.sv]
module hat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/testbench.sv]
module testbench;
   import hat_pkg::*;

   localparam int SLOT_BITS = 12;
   localparam int SLOTS = 1 << SLOT_BITS;
   localparam int FILL_LIMIT = SLOTS * 3 / 4;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 60000;
   localparam int PHASE_WORDS = 375;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   req_word_type pending_words[$];
   rsp_word_type expected_results[$];
   rsp_word_type want;
   logic [63:0] key_pool[$];

   // mirror of the table contents
   bit          table_valid[SLOTS];
   logic [63:0] table_key[SLOTS];
   logic [63:0] table_sum_low[SLOTS];
   logic [63:0] table_sum_high[SLOTS];
   int          table_entries = 0;

   hash_accumulate_table #(.LOG_SLOTS(SLOT_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [SLOT_BITS-1:0] mix_home(input logic [63:0] k);
      logic [63:0] m;
      m = k ^ (k >> MIX_SHIFT);
      m = m * MIX_MUL1;
      m = m ^ (m >> MIX_SHIFT);
      m = m * MIX_MUL2;
      m = m ^ (m >> MIX_SHIFT);
      return m[SLOT_BITS-1:0];
   endfunction

   function automatic rsp_word_type apply_word(input req_word_type w);
      rsp_word_type r;
      logic [SLOT_BITS-1:0] probe;
      logic [127:0] total;
      bit done;
      r = '0;
      r.status = STATUS_DONE;
      done = 1'b0;
      case (w.kind)
         KIND_ACCUM: begin
            probe = mix_home(w.key);
            r.status = STATUS_FULL;
            for (int n = 0; n < SLOTS && !done; n++) begin
               if (!table_valid[probe]) begin
                  done = 1'b1;
                  if (table_entries + 1 <= FILL_LIMIT) begin
                     table_valid[probe] = 1'b1;
                     table_key[probe] = w.key;
                     table_sum_low[probe] = w.value_low;
                     table_sum_high[probe] = w.value_high;
                     table_entries++;
                     r.status = STATUS_INSERTED;
                     r.occupied = 1'b1;
                     r.found_key = w.key;
                     r.sum_low = w.value_low;
                     r.sum_high = w.value_high;
                  end
               end else if (table_key[probe] == w.key) begin
                  done = 1'b1;
                  total = {table_sum_high[probe], table_sum_low[probe]}
                        + {w.value_high, w.value_low};
                  table_sum_low[probe] = total[63:0];
                  table_sum_high[probe] = total[127:64];
                  r.status = STATUS_MERGED;
                  r.occupied = 1'b1;
                  r.found_key = w.key;
                  r.sum_low = total[63:0];
                  r.sum_high = total[127:64];
               end else begin
                  probe = probe + 1'b1;
               end
            end
         end
         KIND_READ: begin
            probe = w.slot_index[SLOT_BITS-1:0];
            if (table_valid[probe]) begin
               r.occupied = 1'b1;
               r.found_key = table_key[probe];
               r.sum_low = table_sum_low[probe];
               r.sum_high = table_sum_high[probe];
            end
         end
         KIND_CLEAR: begin
            foreach (table_valid[i]) table_valid[i] = 1'b0;
            table_entries = 0;
         end
         default: ;
      endcase
      r.entries = table_entries[11:0];
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [127:0] rand_value();
      logic [127:0] v;
      int t;
      case ($urandom_range(4))
         0: v = {$urandom, $urandom, $urandom, $urandom};
         1: begin
            t = int'($urandom_range(2000)) - 1000;
            v = 128'(t);
         end
         2: v = {1'b0, {127{1'b1}}};
         3: v = {1'b1, 127'd0};
         default: v = {$urandom | 32'h8000_0000, $urandom, $urandom, $urandom};
      endcase
      return v;
   endfunction

   function automatic logic [63:0] key_at_home(input logic [SLOT_BITS-1:0] home,
                                               input logic [63:0] other);
      logic [63:0] k;
      do
         k = rand64();
      while (mix_home(k) != home || k == other);
      return k;
   endfunction

   task automatic push_word(input logic [1:0] kind, input logic [63:0] key,
                            input logic [127:0] value, input logic [11:0] idx);
      req_word_type w;
      w.kind = kind;
      w.key = key;
      w.value_low = value[63:0];
      w.value_high = value[127:64];
      w.slot_index = idx;
      pending_words.push_back(w);
      if (kind == KIND_CLEAR)
         key_pool.delete();
   endtask

   task automatic remember_key(input logic [63:0] k);
      if (key_pool.size() < 48)
         key_pool.push_back(k);
      else
         key_pool[$urandom_range(key_pool.size() - 1)] = k;
   endtask

   task automatic push_random_word();
      int pick;
      logic [63:0] k;
      logic [11:0] idx;
      pick = $urandom_range(99);
      if (pick < 40 && key_pool.size() > 0) begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
         push_word(KIND_ACCUM, k, rand_value(), 12'($urandom));
      end else if (pick < 70) begin
         case ($urandom_range(4))
            0, 1: k = rand64();
            2: k = 64'($urandom_range(511));
            3: k = {32'hffff_ffff, $urandom};
            default: k = {$urandom, 32'd0};
         endcase
         push_word(KIND_ACCUM, k, rand_value(), 12'($urandom));
         remember_key(k);
      end else if (pick < 96) begin
         if (pick < 85 && key_pool.size() > 0) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            idx = 12'(mix_home(k) + $urandom_range(3));
         end else begin
            idx = 12'($urandom);
         end
         push_word(KIND_READ, rand64(), rand_value(), idx);
      end else if (pick < 99) begin
         push_word(KIND_UNUSED, rand64(), rand_value(), 12'($urandom));
      end else begin
         push_word(KIND_CLEAR, rand64(), rand_value(), 12'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] expected_val,
                              input logic [63:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s: expected %h, got %h", field, expected_val, actual_val);
         error_count++;
      end
   endtask

   // driver: a stalled word holds, otherwise pick the next word or go idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_word(req_word));
            void'(pending_words.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_word <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_word.status));
            check_field("occupied", 64'(want.occupied), 64'(rsp_word.occupied));
            check_field("found_key", want.found_key, rsp_word.found_key);
            check_field("sum_low", want.sum_low, rsp_word.sum_low);
            check_field("sum_high", want.sum_high, rsp_word.sum_high);
            check_field("entries", 64'(want.entries), 64'(rsp_word.entries));
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] ka, kb, kc, k;
      int sender_plan[4];
      int stall_plan[4];
      sender_plan = '{0, 86, 0, 31};
      stall_plan = '{0, 0, 86, 31};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_word(KIND_ACCUM, 64'd0, 128'd0, 12'd0);
      push_word(KIND_ACCUM, '1, {1'b0, {127{1'b1}}}, 12'd0);
      // carry out of the low half into the sign bit
      push_word(KIND_ACCUM, '1, 128'd1, 12'd0);
      push_word(KIND_ACCUM, '1, '1, 12'd0);
      push_word(KIND_ACCUM, 64'd0, {1'b1, 127'd0}, 12'd0);
      // most negative plus itself wraps to zero
      push_word(KIND_ACCUM, 64'd0, {1'b1, 127'd0}, 12'd0);
      ka = key_at_home('1, '1);
      kb = key_at_home('1, ka);
      kc = key_at_home(mix_home(64'd0), 64'd0);
      push_word(KIND_ACCUM, ka, rand_value(), 12'd0);
      push_word(KIND_ACCUM, kb, rand_value(), 12'd0);
      push_word(KIND_ACCUM, kc, rand_value(), 12'd0);
      push_word(KIND_READ, 64'd0, 128'd0, '1);
      push_word(KIND_READ, 64'd0, 128'd0, 12'd0);
      push_word(KIND_READ, 64'd0, 128'd0, 12'd1);
      push_word(KIND_READ, 64'd0, 128'd0, mix_home(64'd0));
      push_word(KIND_READ, 64'd0, 128'd0, 12'(mix_home(64'd0) + 1'b1));
      push_word(KIND_READ, '1, '1, mix_home('1));
      push_word(KIND_UNUSED, '1, '1, '1);
      push_word(KIND_CLEAR, 64'd0, 128'd0, 12'd0);
      push_word(KIND_READ, 64'd0, 128'd0, '1);
      push_word(KIND_READ, 64'd0, 128'd0, 12'd0);
      push_word(KIND_ACCUM, ka, rand_value(), 12'd0);
      push_word(KIND_ACCUM, kb, rand_value(), 12'd0);
      push_word(KIND_READ, 64'd0, 128'd0, 12'd0);

      // load past three quarters so new keys get refused while old ones still merge
      push_word(KIND_CLEAR, rand64(), rand_value(), 12'($urandom));
      for (int i = 0; i < FILL_LIMIT + 30; i++) begin
         k = rand64();
         push_word(KIND_ACCUM, k, rand_value(), 12'($urandom));
         remember_key(k);
      end
      for (int i = 0; i < 20; i++)
         push_word(KIND_ACCUM, key_pool[$urandom_range(key_pool.size() - 1)],
                   rand_value(), 12'($urandom));
      for (int i = 0; i < 30; i++)
         push_word(KIND_READ, rand64(), rand_value(), 12'($urandom));
      push_word(KIND_CLEAR, rand64(), rand_value(), 12'($urandom));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = sender_plan[p];
         receiver_stall_pct = stall_plan[p];
         for (int i = 0; i < PHASE_WORDS; i++)
            push_random_word();
         wait_drained();
      end

      receiver_stall_pct = 0;
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
